[rtl/direct_mapped_cache_table_unit_macros.svh]
// assertion macros for the direct-mapped cache table unit
// used by the top level only; needs a clock and an active-low reset in scope
`ifndef DIRECT_MAPPED_CACHE_TABLE_UNIT_MACROS_SVH
`define DIRECT_MAPPED_CACHE_TABLE_UNIT_MACROS_SVH

// same-cycle implication, disabled during reset
`define DMC_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled during reset
`define DMC_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error(msg);

`endif

[rtl/dmc_pkg.sv]
// types and constants of the direct-mapped cache table unit
// no dependencies; imported by every module of the block but dmc_ram
package dmc_pkg;

	localparam int ADDR_W           = 32;
	localparam int WORD_W           = 32;
	localparam int TAG_W            = 26;
	localparam int TAG_LSB          = 6;
	localparam int SET_FIELD_W      = 4;
	localparam int SET_LSB          = 2;
	localparam int SET_FIELD_LINES  = 16;
	localparam int OFFSET_W         = 2;
	localparam int BYTE_W           = 8;
	localparam int SET_REDUCE_STEPS = 8;

	localparam logic FUNC_READ  = 1'b0;
	localparam logic FUNC_WRITE = 1'b1;

	typedef struct packed {
		logic              func;
		logic [ADDR_W-1:0] address;
		logic [WORD_W-1:0] write_word;
	} req_t;

	typedef struct packed {
		logic [SET_FIELD_W-1:0] set_index;
		logic                   line_was_valid;
		logic                   tag_match;
		logic [TAG_W-1:0]       line_tag;
		logic [WORD_W-1:0]      line_word;
		logic [BYTE_W-1:0]      read_byte;
	} rsp_t;

	typedef struct packed {
		logic capture;
		logic complete;
	} dmc_cmd_t;

	typedef enum logic {
		ST_IDLE,
		ST_LOOKUP
	} dmc_state_t;

endpackage

[rtl/dmc_ram.sv]
// generic single-write, single-read ram with registered read data
// no dependencies
module dmc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

[rtl/dmc_ctrl.sv]
// controller of the cache table: accept, lookup and result handoff
// depends on dmc_pkg
module dmc_ctrl
	import dmc_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     req_valid,
	output logic     req_ready,
	output logic     rsp_valid,
	input  logic     rsp_ready,
	output dmc_cmd_t cmd
);

	dmc_state_t state_q, state_d;
	logic       out_valid_q;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_d = ST_LOOKUP;
				end
			end
			ST_LOOKUP: begin
				if (!out_valid_q || rsp_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// outputs
	always_comb begin
		req_ready    = 1'b0;
		cmd.capture  = 1'b0;
		cmd.complete = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready   = 1'b1;
				cmd.capture = req_valid;
			end
			ST_LOOKUP: begin
				cmd.complete = !out_valid_q || rsp_ready;
			end
			default: begin
				req_ready = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.complete) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign rsp_valid = out_valid_q;

endmodule

[rtl/dmc_dpath.sv]
// datapath of the cache table: line store, valid bits, result register
// depends on dmc_pkg and dmc_ram
module dmc_dpath
	import dmc_pkg::*;
#(
	parameter int SETS = 16
) (
	input  logic     clk,
	input  logic     arst_n,
	input  dmc_cmd_t cmd,
	input  req_t     req,
	output rsp_t     rsp
);

	localparam int LINES  = (SETS < SET_FIELD_LINES) ? SETS : SET_FIELD_LINES;
	localparam int LINE_W = $clog2(LINES);
	localparam int RAM_W  = TAG_W + WORD_W;

	logic [SET_FIELD_W-1:0] set_field;
	logic [SET_FIELD_W-1:0] set_red;
	logic [LINE_W-1:0]      line_in;

	logic                   func_q;
	logic [TAG_W-1:0]       tag_q;
	logic [OFFSET_W-1:0]    off_q;
	logic [SET_FIELD_W-1:0] set_q;
	logic [LINE_W-1:0]      line_q;
	logic [WORD_W-1:0]      word_q;

	logic                   valid_q [LINES];
	logic [RAM_W-1:0]       rdata;
	logic                   ram_we;

	logic                   was_valid;
	logic [TAG_W-1:0]       old_tag;
	logic [WORD_W-1:0]      old_word;
	rsp_t                   rsp_d;
	rsp_t                   rsp_q;

	// set field reduced to the line count
	always_comb begin
		set_field = req.address[SET_LSB +: SET_FIELD_W];
		set_red   = set_field;
		for (int i = 0; i < SET_REDUCE_STEPS; i++) begin
			if (32'(set_red) >= SETS) begin
				set_red = set_red - SET_FIELD_W'(SETS);
			end
		end
		line_in = LINE_W'(set_red);
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			func_q <= req.func;
			tag_q  <= req.address[TAG_LSB +: TAG_W];
			off_q  <= req.address[OFFSET_W-1:0];
			set_q  <= set_red;
			line_q <= line_in;
			word_q <= req.write_word;
		end
		if (cmd.complete) begin
			rsp_q <= rsp_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LINES; i++) begin
				valid_q[i] <= 1'b0;
			end
		end else if (ram_we) begin
			valid_q[line_q] <= 1'b1;
		end
	end

	assign ram_we = cmd.complete && (func_q == FUNC_WRITE);

	dmc_ram #(
		.WIDTH (RAM_W),
		.DEPTH (LINES)
	) u_line_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (line_q),
		.wdata ({tag_q, word_q}),
		.re    (cmd.capture),
		.raddr (line_in),
		.rdata (rdata)
	);

	// a line never written reads as zero
	always_comb begin
		was_valid = valid_q[line_q];
		old_tag   = was_valid ? rdata[RAM_W-1:WORD_W] : '0;
		old_word  = was_valid ? rdata[WORD_W-1:0] : '0;

		rsp_d.set_index      = set_q;
		rsp_d.line_was_valid = was_valid;
		rsp_d.line_tag       = old_tag;
		rsp_d.line_word      = old_word;
		if (func_q == FUNC_WRITE) begin
			rsp_d.tag_match = 1'b0;
			rsp_d.read_byte = '0;
		end else begin
			rsp_d.tag_match = was_valid && (old_tag == tag_q);
			rsp_d.read_byte = old_word[{off_q, 3'b000} +: BYTE_W];
		end
	end

	assign rsp = rsp_q;

endmodule

[rtl/direct_mapped_cache_table_unit.sv]
// top level of the direct-mapped cache table unit
// depends on dmc_pkg, dmc_ctrl, dmc_dpath, dmc_ram and the macros header
//
// channel  handshake             payload
// request  req_valid/req_ready   req (func, address, write_word)
// result   rsp_valid/rsp_ready   rsp (set, valid, hit, tag, word, byte)
//
// a transaction first registers the read of the line ram in the idle state, then
// evaluates the line in the lookup state and writes it back on a write
// a new request is taken in the cycle after the result is registered, even while it waits
// the lookup holds while an earlier result has not been taken
// valid bits are flops cleared by reset; no clearing pass is needed
`include "direct_mapped_cache_table_unit_macros.svh"

module direct_mapped_cache_table_unit
	import dmc_pkg::*;
#(
	parameter int SETS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	output logic req_ready,
	input  req_t req,
	output logic rsp_valid,
	input  logic rsp_ready,
	output rsp_t rsp
);

	dmc_cmd_t cmd;
	logic     req_fire;

	assign req_fire = req_valid && req_ready;

	dmc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.cmd       (cmd)
	);

	dmc_dpath #(
		.SETS (SETS)
	) u_dpath (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.req    (req),
		.rsp    (rsp)
	);

	`DMC_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, req_fire, !req_ready, "request taken during lookup")
	`DMC_ASSERT_NOW(a_hit_needs_valid, clk, arst_n, rsp_valid && rsp.tag_match, rsp.line_was_valid, "hit on invalid line")
	`DMC_ASSERT_NOW(a_invalid_reads_zero, clk, arst_n, rsp_valid && !rsp.line_was_valid, (rsp.line_tag == '0) && (rsp.line_word == '0), "invalid line not zero")

endmodule

[test/direct_mapped_cache_table_checker.sv]
`timescale 1ns / 1ps
// checker for the direct-mapped cache table unit: mirrors the line store, predicts each
// lookup from its request and compares result transactions in order; depends on dmc_pkg
module direct_mapped_cache_table_checker
	import dmc_pkg::*;
#(
	parameter int SETS = 16
) (
	input  logic clk,
	input  logic arst_n,
	input  logic req_valid,
	input  logic req_ready,
	input  req_t req,
	input  logic rsp_valid,
	input  logic rsp_ready,
	input  rsp_t rsp,
	output int   errors,
	output int   outstanding
);

	logic              present [SETS];
	logic [TAG_W-1:0]  stored_tag [SETS];
	logic [WORD_W-1:0] stored_word [SETS];
	rsp_t              expected_lookups [$];

	function automatic rsp_t cache_access(req_t r);
		int unsigned         line;
		logic [TAG_W-1:0]    addr_tag;
		logic [OFFSET_W-1:0] offset;
		rsp_t                o;
		line = int'(r.address[SET_LSB +: SET_FIELD_W]) % SETS;
		addr_tag = r.address[TAG_LSB +: TAG_W];
		offset = r.address[OFFSET_W-1:0];
		o = '0;
		o.set_index = line[SET_FIELD_W-1:0];
		o.line_was_valid = present[line];
		o.line_tag = stored_tag[line];
		o.line_word = stored_word[line];
		if (r.func == FUNC_WRITE) begin
			present[line] = 1'b1;
			stored_tag[line] = addr_tag;
			stored_word[line] = r.write_word;
		end else begin
			o.tag_match = present[line] && (stored_tag[line] == addr_tag);
			o.read_byte = stored_word[line][offset*BYTE_W +: BYTE_W];
		end
		return o;
	endfunction

	task automatic check_field(string field, logic [WORD_W-1:0] want, logic [WORD_W-1:0] got);
		if (got !== want) begin
			errors++;
			$display("%0t %s expected %h actual %h", $time, field, want, got);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin : watch
		rsp_t want;
		if (!arst_n) begin
			for (int i = 0; i < SETS; i++) begin
				present[i] = 1'b0;
				stored_tag[i] = '0;
				stored_word[i] = '0;
			end
			expected_lookups.delete();
			errors = 0;
			outstanding <= 0;
		end else begin
			if (rsp_valid && rsp_ready) begin
				if (expected_lookups.size() == 0) begin
					errors++;
					$display("%0t result transaction: expected none actual %h", $time, rsp);
				end else begin
					want = expected_lookups.pop_front();
					check_field("set_index", WORD_W'(want.set_index),
						WORD_W'(rsp.set_index));
					check_field("line_was_valid", WORD_W'(want.line_was_valid),
						WORD_W'(rsp.line_was_valid));
					check_field("tag_match", WORD_W'(want.tag_match),
						WORD_W'(rsp.tag_match));
					check_field("line_tag", WORD_W'(want.line_tag),
						WORD_W'(rsp.line_tag));
					check_field("line_word", want.line_word, rsp.line_word);
					check_field("read_byte", WORD_W'(want.read_byte),
						WORD_W'(rsp.read_byte));
				end
			end
			if (req_valid && req_ready)
				expected_lookups.push_back(cache_access(req));
			outstanding <= expected_lookups.size();
		end
	end

endmodule

[test/tb_direct_mapped_cache_table_unit.sv]
`timescale 1ns / 1ps
// testbench top for the direct-mapped cache table unit: drives directed and random accesses
// with random idling on both channels; depends on dmc_pkg, the cache table unit and its checker
module tb_direct_mapped_cache_table_unit;
	import dmc_pkg::*;

	localparam int SETS         = 16;
	localparam int RANDOM_ITEMS = 1730;
	localparam int CYCLE_LIMIT  = 1000000;
	localparam int LONG_HOLD    = 300;
	localparam int HOT_TAGS     = 6;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;
	int   errors;
	int   outstanding;
	int   cycles = 0;
	bit   hold_results = 1'b0;
	logic [TAG_W-1:0] hot_tags [HOT_TAGS];

	always #5 clk = ~clk;

	direct_mapped_cache_table_unit #(
		.SETS(SETS)
	) uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	direct_mapped_cache_table_checker #(
		.SETS(SETS)
	) lookup_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_ready   (req_ready),
		.req         (req),
		.rsp_valid   (rsp_valid),
		.rsp_ready   (rsp_ready),
		.rsp         (rsp),
		.errors      (errors),
		.outstanding (outstanding)
	);

	function automatic int idle_cycles();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 60)
			return 0;
		if (pick < 90)
			return $urandom_range(1, 3);
		if (pick < 97)
			return $urandom_range(4, 12);
		return $urandom_range(20, 60);
	endfunction

	function automatic req_t access(logic func, logic [ADDR_W-1:0] address,
			logic [WORD_W-1:0] word);
		req_t r;
		r.func = func;
		r.address = address;
		r.write_word = word;
		return r;
	endfunction

	// most accesses reuse a few tags so that hits, misses and evictions all occur
	function automatic req_t random_access();
		logic [ADDR_W-1:0] address;
		logic              func;
		address = $urandom;
		if ($urandom_range(0, 3) != 0)
			address[TAG_LSB +: TAG_W] = hot_tags[$urandom_range(0, HOT_TAGS-1)];
		func = ($urandom_range(0, 9) < 4) ? FUNC_WRITE : FUNC_READ;
		return access(func, address, $urandom);
	endfunction

	task automatic send_request(req_t item);
		int gap;
		gap = idle_cycles();
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (!req_ready);
	endtask

	task automatic wait_for_results();
		req_valid <= 1'b0;
		@(posedge clk);
		while (outstanding != 0)
			@(posedge clk);
	endtask

	initial begin
		for (int i = 0; i < HOT_TAGS; i++)
			hot_tags[i] = TAG_W'($urandom);
		hot_tags[0] = '0;
		hot_tags[1] = '1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset contents, fills, hits at every offset, misses and evictions
		send_request(access(FUNC_READ, 32'h0000_0000, 32'h0));
		send_request(access(FUNC_READ, 32'hFFFF_FFFF, 32'h0));
		send_request(access(FUNC_WRITE, 32'h0000_0000, 32'h1122_3344));
		send_request(access(FUNC_READ, 32'h0000_0000, 32'h0));
		send_request(access(FUNC_READ, 32'h0000_0001, 32'h0));
		send_request(access(FUNC_READ, 32'h0000_0002, 32'h0));
		send_request(access(FUNC_READ, 32'h0000_0003, 32'h0));
		send_request(access(FUNC_READ, 32'hFFFF_FFC0, 32'h0));
		send_request(access(FUNC_WRITE, 32'hFFFF_FFFC, 32'hFFFF_FFFF));
		send_request(access(FUNC_READ, 32'hFFFF_FFFF, 32'h0));
		send_request(access(FUNC_WRITE, 32'h0000_003C, 32'h0000_0000));
		send_request(access(FUNC_READ, 32'hFFFF_FFFD, 32'hFFFF_FFFF));
		send_request(access(FUNC_WRITE, 32'h0000_0000, 32'hA5A5_A5A5));
		send_request(access(FUNC_WRITE, 32'hFFFF_FFC1, 32'hDEAD_BEEF));
		send_request(access(FUNC_READ, 32'hFFFF_FFC2, 32'h0));
		send_request(access(FUNC_READ, 32'h0000_001C, 32'h0));
		send_request(access(FUNC_WRITE, 32'h1234_5678, 32'h8000_0001));
		send_request(access(FUNC_READ, 32'h1234_5678, 32'h0));
		send_request(access(FUNC_READ, 32'h1234_5679, 32'h0));
		wait_for_results();

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 300)
				hold_results = 1'b1;
			if (n == 900)
				wait_for_results();
			send_request(random_access());
		end
		wait_for_results();
		repeat (8) @(posedge clk);

		if (errors == 0 && outstanding == 0)
			$display("direct_mapped_cache_table_unit: match");
		else
			$display("direct_mapped_cache_table_unit: mismatch");
		$finish;
	end

	initial begin
		int span;
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			if (hold_results) begin
				rsp_ready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_results = 1'b0;
			end else if ($urandom_range(0, 2) != 0) begin
				rsp_ready <= 1'b1;
				span = ($urandom_range(0, 9) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
				repeat (span) @(posedge clk);
			end else begin
				rsp_ready <= 1'b0;
				span = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40) : $urandom_range(1, 3);
				repeat (span) @(posedge clk);
			end
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("direct_mapped_cache_table_unit: mismatch");
		$finish;
	end

endmodule
